// File: hw/rtl/top_k_index_select_assert.svh
// Assertion helpers used by the checker file.
`ifndef TOP_K_INDEX_SELECT_ASSERT_SVH
`define TOP_K_INDEX_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TKIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TKIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tkis_pkg.sv
`default_nettype none
package tkis_pkg;

   localparam int IN_VALUE_BITS = 32;
   localparam int POS_BITS      = 6;
   localparam int SEL_BITS      = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] SELECT_COUNT_ADDR  = 3'd0;
   localparam logic [SEL_BITS-1:0]      SELECT_COUNT_RESET = 7'd1;

   // controller -> datapath
   typedef struct packed {
      logic start_scan;
      logic emit_mode;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic last_round;
      logic k_zero;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/top_k_index_select.sv
// Loads one element per cycle with no result; busy stays low between elements.
// After the marked element (n stored, k = min(select_count, n)) busy stays high
// through the check, k selection scans and one emit scan, each over the n entries
// on the single registered read port, then done; only check and done if k is 0.
// Results, one per cycle at most, end by the last busy cycle; no stall possible.
// Reset clears the element count and sets select_count to 1; memory is kept.
`default_nettype none
module top_k_index_select
   import tkis_pkg::*;
#(
   parameter int MAX_LEN    = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [IN_VALUE_BITS-1:0] req_value,
   input  wire logic                            req_is_last,
   output logic                                 rsp_valid,
   output logic             [POS_BITS-1:0]      rsp_position,
   output logic                                 rsp_final_index,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic        [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic        [CSR_DATA_BITS-1:0] pwdata,
   output logic             [CSR_DATA_BITS-1:0] prdata,
   output logic                                 pready
);

   logic [SEL_BITS-1:0] select_count_ff;
   logic                accept;
   cmd_type             cmd;
   status_type          status;

   assign pready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_count_ff <= SELECT_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && (paddr == SELECT_COUNT_ADDR)) begin
         select_count_ff <= pwdata[SEL_BITS-1:0];
      end
   end

   assign prdata = (paddr == SELECT_COUNT_ADDR) ? CSR_DATA_BITS'(select_count_ff) : '0;

   tkis_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_last (req_is_last),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   tkis_datapath #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_value        (req_value),
      .in_last         (req_is_last),
      .select_count    (select_count_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_position    (rsp_position),
      .rsp_final_index (rsp_final_index)
   );

endmodule
`default_nettype wire

// File: hw/rtl/tkis_ctrl.sv
`default_nettype none
module tkis_ctrl
   import tkis_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       in_last,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SELECT,
      ST_EMIT,
      ST_DONE
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         cmd_ff.start_scan <= 1'b0;
         cmd_ff.finish     <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && in_last) begin
                  state_ff <= ST_CHECK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_CHECK: begin
               if (status.k_zero) begin
                  state_ff      <= ST_DONE;
                  cmd_ff.finish <= 1'b1;
               end else begin
                  state_ff          <= ST_SELECT;
                  cmd_ff.start_scan <= 1'b1;
               end
            end
            ST_SELECT: begin
               if (status.scan_done) begin
                  cmd_ff.start_scan <= 1'b1;
                  // after the k-th pick the threshold is known: emit pass
                  if (status.last_round) begin
                     state_ff         <= ST_EMIT;
                     cmd_ff.emit_mode <= 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               if (status.scan_done) begin
                  state_ff         <= ST_DONE;
                  cmd_ff.emit_mode <= 1'b0;
                  cmd_ff.finish    <= 1'b1;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign cmd  = cmd_ff;
   assign busy = busy_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tkis_datapath.sv
`default_nettype none
module tkis_datapath
   import tkis_pkg::*;
#(
   parameter int MAX_LEN    = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic signed [IN_VALUE_BITS-1:0] in_value,
   input  wire logic                            in_last,
   input  wire logic        [SEL_BITS-1:0]      select_count,
   input  wire cmd_type                         cmd,
   output status_type                           status,
   output logic                                 rsp_valid,
   output logic             [POS_BITS-1:0]      rsp_position,
   output logic                                 rsp_final_index
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int KW = (CW > SEL_BITS) ? CW : SEL_BITS;
   localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [VALUE_BITS-1:0] value_store [MAX_LEN];

   logic [CW-1:0]         count_ff, n_ff, k_ff, round_ff, emit_cnt_ff;
   logic [AW-1:0]         addr_ff, rd_idx_ff;
   logic                  scan_on_ff, rd_valid_ff, rd_last_ff;
   logic [VALUE_BITS-1:0] rdata_ff;
   logic                  best_found_ff, prev_ok_ff;
   logic [VALUE_BITS-1:0] best_val_ff, prev_val_ff;
   logic [AW-1:0]         best_idx_ff, prev_idx_ff;
   logic                  rsp_valid_ff, rsp_final_ff;
   logic [POS_BITS-1:0]   rsp_position_ff;

   logic [CW-1:0]         count_in;
   logic [KW-1:0]         sel_wide, n_wide;
   logic [CW-1:0]         k_in;
   logic [VALUE_BITS-1:0] store_key;
   logic                  not_full, last_addr;
   logic                  eligible, take, chosen, emit_hit;
   logic [VALUE_BITS-1:0] best_val_in;
   logic [AW-1:0]         best_idx_in;

   // offset binary so an unsigned compare orders signed values
   assign store_key = VALUE_BITS'(in_value) ^ SIGN_FLIP;
   assign not_full  = (count_ff < CW'(MAX_LEN));
   assign count_in  = not_full ? (count_ff + CW'(1)) : count_ff;
   assign sel_wide  = KW'(select_count);
   assign n_wide    = KW'(count_in);
   assign k_in      = (sel_wide > n_wide) ? CW'(n_wide) : CW'(sel_wide);
   assign last_addr = (CW'(addr_ff) == (n_ff - CW'(1)));

   // a round picks the best entry ranked below the previous pick
   // (rank: larger value first, lower index first among equals)
   assign eligible = !prev_ok_ff || (rdata_ff < prev_val_ff) ||
                     ((rdata_ff == prev_val_ff) && (rd_idx_ff > prev_idx_ff));
   assign take     = eligible && (!best_found_ff || (rdata_ff > best_val_ff));
   assign best_val_in = take ? rdata_ff : best_val_ff;
   assign best_idx_in = take ? rd_idx_ff : best_idx_ff;

   // chosen: ranked at or above the k-th pick
   assign chosen   = (rdata_ff > prev_val_ff) ||
                     ((rdata_ff == prev_val_ff) && (rd_idx_ff <= prev_idx_ff));
   assign emit_hit = rd_valid_ff && cmd.emit_mode && chosen;

   always_ff @(posedge clock) begin
      if (accept && not_full) begin
         value_store[count_ff[AW-1:0]] <= store_key;
      end
      rdata_ff <= value_store[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         n_ff          <= '0;
         k_ff          <= '0;
         round_ff      <= '0;
         emit_cnt_ff   <= '0;
         addr_ff       <= '0;
         scan_on_ff    <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         prev_ok_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            if (in_last) begin
               n_ff          <= count_in;
               k_ff          <= k_in;
               round_ff      <= '0;
               emit_cnt_ff   <= '0;
               prev_ok_ff    <= 1'b0;
               best_found_ff <= 1'b0;
            end
         end
         if (cmd.finish) begin
            count_ff <= '0;
         end

         if (cmd.start_scan) begin
            addr_ff    <= '0;
            scan_on_ff <= 1'b1;
         end else if (scan_on_ff) begin
            addr_ff <= addr_ff + AW'(1);
            if (last_addr) begin
               scan_on_ff <= 1'b0;
            end
         end
         rd_valid_ff <= scan_on_ff && !cmd.start_scan;
         rd_last_ff  <= scan_on_ff && !cmd.start_scan && last_addr;

         if (rd_valid_ff && !cmd.emit_mode) begin
            if (rd_last_ff) begin
               prev_val_ff   <= best_val_in;
               prev_idx_ff   <= best_idx_in;
               prev_ok_ff    <= 1'b1;
               best_found_ff <= 1'b0;
               round_ff      <= round_ff + CW'(1);
            end else begin
               best_val_ff   <= best_val_in;
               best_idx_ff   <= best_idx_in;
               best_found_ff <= best_found_ff || take;
            end
         end

         rsp_valid_ff <= emit_hit;
         if (emit_hit) begin
            emit_cnt_ff <= emit_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (emit_hit) begin
         rsp_position_ff <= POS_BITS'(rd_idx_ff);
         rsp_final_ff    <= (emit_cnt_ff == (k_ff - CW'(1)));
      end
   end

   assign status.scan_done  = rd_valid_ff && rd_last_ff;
   assign status.last_round = (round_ff == (k_ff - CW'(1)));
   assign status.k_zero     = (k_ff == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_final_index = rsp_final_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tkis_checker.sv
`default_nettype none
`include "top_k_index_select_assert.svh"
module tkis_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_is_last,
   input wire logic rsp_valid,
   input wire logic rsp_final_index,
   input wire logic psel,
   input wire logic penable,
   input wire logic pready
);

   // results only come out while a run is in progress
   `TKIS_ASSERT_NOW(a_rsp_in_run, rsp_valid, busy, "result outside a run")
   // a marked element starts a run
   `TKIS_ASSERT_NEXT(a_last_starts, start && !busy && req_is_last, busy, "run did not start")
   // nothing follows the final index of a run
   `TKIS_ASSERT_NEXT(a_final_ends, rsp_valid && rsp_final_index, !rsp_valid, "result after final")
   `TKIS_ASSERT_NOW(a_apb_ready, psel && penable, pready, "access cycle without pready")

endmodule

bind top_k_index_select tkis_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_is_last     (req_is_last),
   .rsp_valid       (rsp_valid),
   .rsp_final_index (rsp_final_index),
   .psel            (psel),
   .penable         (penable),
   .pready          (pready)
);
`default_nettype wire

// File: sim/top_k_index_select_test.sv
`default_nettype none
module top_k_index_select_test;
   import tkis_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int RANDOM_ITEMS = 205;
   localparam int DRAIN_GUARD = 200000;

   typedef struct {
      logic [POS_BITS-1:0] position;
      logic                final_index;
   } position_result_type;

   // sel < 0: keep the current count; exp_n < 0: results come from the predictor
   typedef struct {
      int           sel;
      logic [31:0]  value;
      bit           last;
      int           exp_n;
      int           exp_pos;
   } directed_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic signed [IN_VALUE_BITS-1:0] req_value = '0;
   logic                            req_is_last = 1'b0;
   logic                            rsp_valid;
   logic        [POS_BITS-1:0]      rsp_position;
   logic                            rsp_final_index;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic        [CSR_ADDR_BITS-1:0] paddr = '0;
   logic        [CSR_DATA_BITS-1:0] pwdata = '0;
   logic        [CSR_DATA_BITS-1:0] prdata;
   logic                            pready;

   // predictor state
   logic signed [IN_VALUE_BITS-1:0] element_store [STORE_DEPTH];
   int unsigned                     element_count = 0;
   logic        [SEL_BITS-1:0]      select_count_model = SELECT_COUNT_RESET;
   int unsigned                     drain_cycles = 4;
   position_result_type             expected_positions [$];
   position_result_type             oldest;
   int                              failures = 0;

   directed_row_type directed_rows [22] = '{
      '{-1, 32'h0000_0000, 1,  1, 0},   // lone element right after reset
      '{-1, 32'h8000_0000, 0, -1, 0},
      '{-1, 32'h7FFF_FFFF, 1,  1, 1},
      '{-1, 32'h7FFF_FFFF, 0, -1, 0},
      '{-1, 32'h8000_0000, 1,  1, 0},
      '{-1, 32'h0001_0000, 0, -1, 0},   // all equal: lowest index wins
      '{-1, 32'h0001_0000, 0, -1, 0},
      '{-1, 32'h0001_0000, 1,  1, 0},
      '{ 0, 32'h1234_5678, 0, -1, 0},   // zero count: run ends with no output
      '{-1, 32'hFFFF_FFFF, 1,  0, 0},
      '{127, 32'h0000_0003, 0, -1, 0},  // count above length saturates
      '{-1, 32'hFFFF_FFFE, 0, -1, 0},
      '{-1, 32'h5555_5555, 1, -1, 0},
      '{64, 32'hFFFF_FFFF, 0, -1, 0},
      '{-1, 32'h0001_0000, 0, -1, 0},
      '{-1, 32'hFFFF_8000, 0, -1, 0},
      '{-1, 32'h0000_0000, 1, -1, 0},
      '{ 2, 32'hFFFF_0000, 0, -1, 0},
      '{-1, 32'h0000_0001, 0, -1, 0},
      '{-1, 32'hFFFF_0000, 0, -1, 0},
      '{-1, 32'h0000_0001, 0, -1, 0},
      '{-1, 32'hAAAA_AAAA, 1, -1, 0}
   };

   top_k_index_select DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_position    (rsp_position),
      .rsp_final_index (rsp_final_index),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stores one element; on the marked one picks the k largest and queues
   // their indices in ascending order when keep is set.
   function automatic void select_top_positions(input logic signed [31:0] v,
                                                input bit last, input bit keep);
      bit          picked [STORE_DEPTH];
      int unsigned k;
      int unsigned best;
      int unsigned emitted;
      bit          found;
      position_result_type item;
      if (element_count < STORE_DEPTH) begin
         element_store[element_count] = v;
         element_count++;
      end
      if (!last)
         return;
      k = (select_count_model > element_count) ? element_count : select_count_model;
      drain_cycles = (k + 1) * (element_count + 2) + 8;
      for (int r = 0; r < k; r++) begin
         found = 1'b0;
         best = 0;
         for (int i = 0; i < element_count; i++) begin
            if (!picked[i] && (!found || element_store[i] > element_store[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         if (found)
            picked[best] = 1'b1;
      end
      emitted = 0;
      for (int i = 0; i < element_count; i++) begin
         if (picked[i]) begin
            item.position = i[POS_BITS-1:0];
            item.final_index = (emitted == k - 1);
            if (keep)
               expected_positions.push_back(item);
            emitted++;
         end
      end
      element_count = 0;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return 0;
      else if (r < 9)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return (32'($urandom_range(0, 4)) - 32'd2) << 16;   // frequent ties
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SEL_BITS-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd64;
         3: return 7'd127;
         4: return 7'($urandom_range(0, 127));
         default: return 7'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 8);
      else if (r < 96)
         return $urandom_range(9, 40);
      else if (r < 98)
         return $urandom_range(41, 64);
      return $urandom_range(65, 72);   // overflow: extra elements dropped
   endfunction

   // Called right after a rising edge; start stays high when no gap follows.
   task automatic send_element(input logic [31:0] v, input bit last, input bit keep,
                               input bit no_gap);
      int unsigned gap;
      start <= 1'b1;
      req_value <= v;
      req_is_last <= last;
      do @(posedge clock); while (busy);
      select_top_positions(v, last, keep);
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         req_value <= $urandom;
         req_is_last <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      repeat (drain_cycles) @(posedge clock);
      while (busy || expected_positions.size() != 0) @(posedge clock);
   endtask

   task automatic write_select_count(input logic [SEL_BITS-1:0] count);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SELECT_COUNT_ADDR;
      pwdata <= CSR_DATA_BITS'(count);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      select_count_model = count;
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[SEL_BITS-1:0] !== count) begin
         $error("select_count: expected %0d, actual %0d", count, prdata[SEL_BITS-1:0]);
         failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_positions.size() == 0) begin
            $error("unexpected transaction: position %0d final_index %0d",
                   rsp_position, rsp_final_index);
            failures++;
         end else begin
            oldest = expected_positions.pop_front();
            if (rsp_position !== oldest.position) begin
               $error("position: expected %0d, actual %0d", oldest.position, rsp_position);
               failures++;
            end
            if (rsp_final_index !== oldest.final_index) begin
               $error("final_index: expected %0d, actual %0d",
                      oldest.final_index, rsp_final_index);
               failures++;
            end
         end
      end
   end

   initial begin
      int unsigned stored_items;
      int unsigned len;
      int unsigned guard;
      int unsigned groups;
      bit          no_idle;
      position_result_type typed;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         if (directed_rows[n].sel >= 0) begin
            settle();
            write_select_count(directed_rows[n].sel[SEL_BITS-1:0]);
         end
         if (directed_rows[n].last && directed_rows[n].exp_n >= 0) begin
            if (directed_rows[n].exp_n == 1) begin
               typed.position = directed_rows[n].exp_pos[POS_BITS-1:0];
               typed.final_index = 1'b1;
               expected_positions.push_back(typed);
            end
            send_element(directed_rows[n].value, 1'b1, 1'b0, 1'b0);
         end else begin
            send_element(directed_rows[n].value, directed_rows[n].last, 1'b1, 1'b0);
         end
      end

      stored_items = 0;
      while (stored_items < RANDOM_ITEMS) begin
         settle();
         write_select_count(pick_count());
         groups = $urandom_range(3, 8);
         for (int g = 0; g < groups && stored_items < RANDOM_ITEMS; g++) begin
            len = pick_length();
            no_idle = ($urandom_range(0, 3) == 0);
            for (int e = 0; e < len; e++) begin
               send_element(pick_value(), e == len - 1, 1'b1, no_idle);
               if (e < STORE_DEPTH)
                  stored_items++;
            end
         end
      end

      start <= 1'b0;
      guard = 0;
      while (expected_positions.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (drain_cycles) @(posedge clock);
      if (expected_positions.size() != 0) begin
         $error("%0d expected positions never arrived", expected_positions.size());
         failures++;
      end
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3200000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
